// File: rtl/lcd_mode_timing_registers_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef LCD_MODE_TIMING_REGISTERS_UNIT_DEFINES_SVH
`define LCD_MODE_TIMING_REGISTERS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while dis is high.
`define LCDT_ASSERT_IMP(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("lcdt assertion failed");

// Next-cycle implication, disabled while dis is high.
`define LCDT_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("lcdt assertion failed");

`endif

// File: rtl/lcdt_pkg.sv
// Types and constants of the LCD mode timing and register unit.
package lcdt_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [3:0] REG_LCDC = 4'd0;
    localparam logic [3:0] REG_STAT = 4'd1;
    localparam logic [3:0] REG_SCY  = 4'd2;
    localparam logic [3:0] REG_SCX  = 4'd3;
    localparam logic [3:0] REG_LY   = 4'd4;
    localparam logic [3:0] REG_LYC  = 4'd5;
    localparam logic [3:0] REG_DMA  = 4'd6;
    localparam logic [3:0] REG_WX   = 4'd11;

    localparam logic [1:0] CODE_HBLANK = 2'd0;
    localparam logic [1:0] CODE_VBLANK = 2'd1;
    localparam logic [1:0] CODE_OAM    = 2'd2;
    localparam logic [1:0] CODE_XFER   = 2'd3;

    localparam logic [8:0] LEN_HBLANK = 9'd204;
    localparam logic [8:0] LEN_VBLANK = 9'd456;
    localparam logic [8:0] LEN_OAM    = 9'd80;
    localparam logic [8:0] LEN_XFER   = 9'd172;

    localparam logic [7:0] STAT_FIXED = 8'h80;
    localparam logic [7:0] PAD_READ   = 8'hFF;

    typedef enum logic [3:0] {
        MS_HBLANK = 4'b0001,
        MS_VBLANK = 4'b0010,
        MS_OAM    = 4'b0100,
        MS_XFER   = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [7:0] current_line;
        logic [1:0] current_mode;
        logic       stat_irq;
        logic       vblank_irq;
        logic [7:0] read_data;
    } t_result;

endpackage

// File: rtl/lcd_mode_timing_registers_unit.sv
// Top level of the LCD mode timing and register unit.
//
// Input stream (s side): one beat is a tick of one machine cycle, a register
// read or a register write, selected by tuser. Each beat yields exactly one
// result beat on the m side, in order: the read byte (zero unless a read),
// the vblank and STAT interrupt requests raised by that beat, and the mode
// and line counter after it.
// The result is registered in the output register, or in the skid one on a stall.
// Throughput: one beat per cycle while o_s_tready is high; the sequencer state
// updates in the cycle a beat is accepted, so back-to-back ticks need no gaps.
// Output side is an output register backed by a one-beat skid register;
// o_s_tready is registered and drops only once both are full, so a stall on
// i_m_tready stops the input after at most one more beat. No beat is lost.
// Reset (i_rst_n low, synchronous): hblank, line 0, countdown 456, all
// registers zero, both output stages empty.
module lcd_mode_timing_registers_unit
    import lcdt_pkg::*;
#(
    parameter int TICK_CYCLES   = 4,
    parameter int VISIBLE_LINES = 144,
    parameter int TOTAL_LINES   = 154
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // reg_index[3:0], write_data[11:4], zero[15:12]
    input  logic [1:0]  i_s_tuser,   // operation[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // read_data[7:0], vblank_irq[8], stat_irq[9],
                                     // current_mode[11:10], current_line[19:12],
                                     // zero[23:20]
);

    t_result res;
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    logic    in_fire, out_fire;

    assign o_s_tready = !r_skid_valid;
    assign in_fire    = i_s_tvalid & o_s_tready;
    assign out_fire   = r_out_valid & i_m_tready;

    lcdt_core #(
        .TICK_CYCLES   (TICK_CYCLES),
        .VISIBLE_LINES (VISIBLE_LINES),
        .TOTAL_LINES   (TOTAL_LINES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (in_fire),
        .i_operation  (i_s_tuser),
        .i_reg_index  (i_s_tdata[3:0]),
        .i_write_data (i_s_tdata[11:4]),
        .o_result     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_fire) begin
                r_out <= res;
            end
        end else if (in_fire) begin
            r_skid <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out};

endmodule

// File: rtl/lcdt_core.sv
// Mode/line sequencer and register bank; result of the accepted beat.
module lcdt_core
    import lcdt_pkg::*;
#(
    parameter int TICK_CYCLES   = 4,
    parameter int VISIBLE_LINES = 144,
    parameter int TOTAL_LINES   = 154
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [1:0] i_operation,
    input  logic [3:0] i_reg_index,
    input  logic [7:0] i_write_data,
    output t_result    o_result
);

    localparam logic [8:0] TICK = 9'(TICK_CYCLES);
    localparam logic [7:0] VIS  = 8'(VISIBLE_LINES);
    localparam logic [7:0] TOT  = 8'(TOTAL_LINES);

    t_mode      r_mode, n_mode;
    logic [7:0] r_line, n_line;
    logic [8:0] r_cycles, n_cycles;
    logic [7:0] r_lcdc, n_lcdc;
    logic [3:0] r_en, n_en;
    logic       r_coin, n_coin;
    logic [7:0] r_lyc, n_lyc;
    logic [7:0] r_plain [8];

    logic [7:0] line_inc;
    logic       slot_ok;
    logic [2:0] slot;
    logic       chk;
    logic [7:0] rd;
    logic       vb, st;
    logic       plain_we;

    function automatic logic [1:0] mode_code(t_mode m);
        case (m)
            MS_HBLANK: mode_code = CODE_HBLANK;
            MS_VBLANK: mode_code = CODE_VBLANK;
            MS_OAM:    mode_code = CODE_OAM;
            MS_XFER:   mode_code = CODE_XFER;
            default:   mode_code = CODE_HBLANK;
        endcase
    endfunction

    function automatic logic [8:0] mode_len(t_mode m);
        case (m)
            MS_HBLANK: mode_len = LEN_HBLANK;
            MS_VBLANK: mode_len = LEN_VBLANK;
            MS_OAM:    mode_len = LEN_OAM;
            MS_XFER:   mode_len = LEN_XFER;
            default:   mode_len = LEN_HBLANK;
        endcase
    endfunction

    assign line_inc = r_line + 8'd1;

    // SCY, SCX, then DMA..WX map to slots 0..7
    always_comb begin
        slot_ok = 1'b0;
        slot    = 3'd0;
        if (i_reg_index == REG_SCY || i_reg_index == REG_SCX) begin
            slot_ok = 1'b1;
            slot    = 3'(i_reg_index - REG_SCY);
        end else if (i_reg_index >= REG_DMA && i_reg_index <= REG_WX) begin
            slot_ok = 1'b1;
            slot    = 3'(i_reg_index - 4'd4);
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_line   = r_line;
        n_cycles = r_cycles;
        n_lcdc   = r_lcdc;
        n_en     = r_en;
        n_coin   = r_coin;
        n_lyc    = r_lyc;
        chk      = 1'b0;
        rd       = 8'd0;
        vb       = 1'b0;
        st       = 1'b0;
        plain_we = 1'b0;
        case (i_operation)
            OP_TICK: begin
                if (r_cycles > TICK) begin
                    n_cycles = r_cycles - TICK;
                end else begin
                    case (r_mode)
                        MS_HBLANK: begin
                            n_line = line_inc;
                            n_mode = (line_inc < VIS) ? MS_OAM : MS_VBLANK;
                            chk    = 1'b1;
                        end
                        MS_VBLANK: begin
                            chk = 1'b1;
                            if (line_inc >= TOT) begin
                                n_line = 8'd0;
                                n_mode = MS_OAM;
                            end else begin
                                n_line = line_inc;
                            end
                        end
                        MS_OAM:  n_mode = MS_XFER;
                        MS_XFER: n_mode = MS_HBLANK;
                        default: n_mode = MS_HBLANK;
                    endcase
                    if (chk) begin
                        n_coin = (n_line == r_lyc);
                        st     = n_coin & r_en[3];
                    end
                    if (n_mode != r_mode) begin
                        case (n_mode)
                            MS_HBLANK: st = st | r_en[0];
                            MS_VBLANK: begin
                                vb = 1'b1;
                                st = st | r_en[1] | r_en[2];
                            end
                            MS_OAM:  st = st | r_en[2];
                            default: ;
                        endcase
                    end
                    n_cycles = mode_len(n_mode);
                end
            end
            OP_READ: begin
                if (slot_ok) begin
                    rd = r_plain[slot];
                end else begin
                    case (i_reg_index)
                        REG_LCDC: rd = r_lcdc;
                        REG_STAT: rd = STAT_FIXED | {1'b0, r_en, r_coin, mode_code(r_mode)};
                        REG_LY:   rd = r_line;
                        REG_LYC:  rd = r_lyc;
                        default:  rd = PAD_READ;
                    endcase
                end
            end
            OP_WRITE: begin
                if (slot_ok) begin
                    plain_we = 1'b1;
                end else begin
                    case (i_reg_index)
                        REG_LCDC: n_lcdc = i_write_data;
                        REG_STAT: begin
                            n_en   = i_write_data[6:3];
                            n_coin = i_write_data[2];
                        end
                        REG_LY: begin
                            n_line = i_write_data;
                            n_coin = (i_write_data == r_lyc);
                            st     = n_coin & r_en[3];
                        end
                        REG_LYC: begin
                            n_lyc  = i_write_data;
                            n_coin = (r_line == i_write_data);
                            st     = n_coin & r_en[3];
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MS_HBLANK;
            r_line   <= 8'd0;
            r_cycles <= LEN_VBLANK;
            r_lcdc   <= 8'd0;
            r_en     <= 4'd0;
            r_coin   <= 1'b0;
            r_lyc    <= 8'd0;
            for (int i = 0; i < 8; i++) begin
                r_plain[i] <= 8'd0;
            end
        end else if (i_fire) begin
            r_mode   <= n_mode;
            r_line   <= n_line;
            r_cycles <= n_cycles;
            r_lcdc   <= n_lcdc;
            r_en     <= n_en;
            r_coin   <= n_coin;
            r_lyc    <= n_lyc;
            if (plain_we) begin
                r_plain[slot] <= i_write_data;
            end
        end
    end

    assign o_result = '{
        current_line: n_line,
        current_mode: mode_code(n_mode),
        stat_irq:     st,
        vblank_irq:   vb,
        read_data:    rd
    };

endmodule

// File: rtl/lcdt_checker.sv
// Port-level checker for the LCD mode timing unit, with its bind.
`include "lcd_mode_timing_registers_unit_defines.svh"

module lcdt_checker
    import lcdt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata
);

    `LCDT_ASSERT_NEXT(a_rst_empty, i_clk, 1'b0, !i_rst_n, !o_m_tvalid && o_s_tready)
    `LCDT_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid)
    `LCDT_ASSERT_IMP(a_full_has_out, i_clk, !i_rst_n, !o_s_tready, o_m_tvalid)
    `LCDT_ASSERT_IMP(a_vblank_mode, i_clk, !i_rst_n, o_m_tvalid && o_m_tdata[8],
        o_m_tdata[11:10] == CODE_VBLANK)

endmodule

bind lcd_mode_timing_registers_unit lcdt_checker u_lcdt_checker (.*);
